>>> hw/rtl/thread_corner_tracker_macros.svh
// Assertion helpers for the file that checks its own logic.
`ifndef THREAD_CORNER_TRACKER_MACROS_SVH
`define THREAD_CORNER_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thread corner tracker check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thread corner tracker check failed");

`endif

>>> hw/rtl/tct_pkg.sv
`timescale 1ns / 1ps

package tct_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int CNT_W       = $clog2(MAX_COLUMNS);
    localparam int PIX_W       = 8;
    localparam int COORD_W     = 10;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_COLUMNS - 1);

    typedef enum logic [1:0] {
        CFG_EDGE_THRESHOLD = 2'd0,
        CFG_MIN_EDGES      = 2'd1,
        CFG_HEIGHT_WINDOW  = 2'd2,
        CFG_PITCH_MARGIN   = 2'd3
    } cfg_index_t;

    localparam logic [7:0]         EDGE_THRESHOLD_RESET = 8'd128;
    localparam logic [7:0]         MIN_EDGES_RESET      = 8'd4;
    localparam logic [COORD_W-1:0] HEIGHT_WINDOW_RESET  = 10'd10;
    localparam logic [COORD_W-1:0] PITCH_MARGIN_RESET   = 10'd5;

    typedef struct packed {
        logic [7:0]         edge_threshold;
        logic [7:0]         min_edges;
        logic [COORD_W-1:0] height_window;
        logic [COORD_W-1:0] pitch_margin;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_value;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row_index;
        logic               lower_half;
        logic               half_start;
        logic               row_end;
    } in_word_t;

    typedef struct packed {
        logic               half_out;
        logic [COORD_W-1:0] row_out;
        logic [COORD_W-1:0] rising_edges;
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] left_y;
        logic [COORD_W-1:0] right_x;
        logic [COORD_W-1:0] right_y;
        logic               corners_found;
        logic               corners_moved;
    } out_word_t;

    typedef struct packed {
        logic [PIX_W-1:0]   prev_pixel;
        logic [CNT_W-1:0]   edge_count;
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] latest_x;
        logic [COORD_W-1:0] before_x;
        logic               found;
    } row_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } corner_t;

    typedef struct packed {
        corner_t left;
        corner_t right;
    } corner_pair_t;

endpackage

>>> hw/rtl/thread_corner_tracker.sv
`timescale 1ns / 1ps
// Streaming corner finder for the rising edges of a thread profile. It takes one pixel word
// per clock on s_valid/s_ready while no row end word is waiting, and returns one result word
// on m_valid/m_ready at each row end; a row end word goes from the input register to the result
// register. Only a row end word waits in the input register, and only while the result register
// holds a word that is not being taken; no new word is taken while it waits. The rate is set by
// the single pass of edge detection and corner update between the input register and the result
// register, with the row and corner state kept in their own registers. Configuration writes must
// be made while no word is in flight.

`include "thread_corner_tracker_macros.svh"

module thread_corner_tracker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [1:0]                         cfg_index,
    input  logic [tct_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  tct_pkg::in_word_t                  s_word,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tct_pkg::out_word_t                 m_word
);

    tct_pkg::cfg_t         cfg_reg;
    tct_pkg::in_word_t     in_reg;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    tct_pkg::row_state_t   state_reg;
    tct_pkg::row_state_t   state_next;
    tct_pkg::corner_pair_t top_reg;
    tct_pkg::corner_pair_t top_next;
    tct_pkg::corner_pair_t bottom_reg;
    tct_pkg::corner_pair_t bottom_next;
    tct_pkg::out_word_t    out_reg;
    tct_pkg::out_word_t    out_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  step_fire;
    logic                  s_fire;

    assign step_fire = in_valid_reg && (!in_reg.row_end || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_fire;
    assign s_fire    = s_valid && s_ready;

    assign in_valid_next  = s_fire || (in_valid_reg && !step_fire);
    assign out_valid_next = (out_valid_reg && !m_ready) || (step_fire && in_reg.row_end);

    tct_pixel_step u_step (
        .word        (in_reg),
        .cfg         (cfg_reg),
        .state       (state_reg),
        .top         (top_reg),
        .bottom      (bottom_reg),
        .state_next  (state_next),
        .top_next    (top_next),
        .bottom_next (bottom_next),
        .result      (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.edge_threshold <= tct_pkg::EDGE_THRESHOLD_RESET;
            cfg_reg.min_edges      <= tct_pkg::MIN_EDGES_RESET;
            cfg_reg.height_window  <= tct_pkg::HEIGHT_WINDOW_RESET;
            cfg_reg.pitch_margin   <= tct_pkg::PITCH_MARGIN_RESET;
        end else if (cfg_wr_en) begin
            case (tct_pkg::cfg_index_t'(cfg_index))
                tct_pkg::CFG_EDGE_THRESHOLD: begin
                    cfg_reg.edge_threshold <= cfg_wdata[7:0];
                end
                tct_pkg::CFG_MIN_EDGES: begin
                    cfg_reg.min_edges <= cfg_wdata[7:0];
                end
                tct_pkg::CFG_HEIGHT_WINDOW: begin
                    cfg_reg.height_window <= cfg_wdata;
                end
                tct_pkg::CFG_PITCH_MARGIN: begin
                    cfg_reg.pitch_margin <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            top_reg       <= '0;
            bottom_reg    <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire) begin
                state_reg  <= state_next;
                top_reg    <= top_next;
                bottom_reg <= bottom_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= s_word;
        end
        if (step_fire && in_reg.row_end) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

    // A finished row always lands in the result register on the following cycle.
    `TCT_ASSERT_NEXT(a_row_end_gives_result, aclk, aresetn, step_fire && in_reg.row_end, m_valid)
    // A waiting result is never overwritten by the next row end.
    `TCT_ASSERT_NOW(a_no_overwrite, aclk, aresetn, out_valid_reg && !m_ready, !(step_fire && in_reg.row_end))
    // A held input word stays in the input register until it is processed.
    `TCT_ASSERT_NEXT(a_input_held, aclk, aresetn, in_valid_reg && !step_fire, in_valid_reg)

endmodule

>>> hw/rtl/tct_pixel_step.sv
`timescale 1ns / 1ps

module tct_pixel_step (
    input  tct_pkg::in_word_t     word,
    input  tct_pkg::cfg_t         cfg,
    input  tct_pkg::row_state_t   state,
    input  tct_pkg::corner_pair_t top,
    input  tct_pkg::corner_pair_t bottom,
    output tct_pkg::row_state_t   state_next,
    output tct_pkg::corner_pair_t top_next,
    output tct_pkg::corner_pair_t bottom_next,
    output tct_pkg::out_word_t    result
);

    tct_pkg::row_state_t        st;
    tct_pkg::corner_pair_t      pair;
    logic                       is_edge;
    logic [tct_pkg::PIX_W-1:0]  rise;
    logic [tct_pkg::COORD_W-1:0] edge_x;
    logic                       meets;
    logic [tct_pkg::COORD_W-1:0] left_dist;
    logic [tct_pkg::COORD_W-1:0] right_dist;
    logic signed [tct_pkg::COORD_W:0] left_pitch;
    logic signed [tct_pkg::COORD_W:0] right_pitch;
    logic signed [tct_pkg::COORD_W:0] pitch_limit;
    logic                       moved;

    always_comb begin
        st          = state;
        st.found    = state.found & ~word.half_start;
        pair        = word.lower_half ? bottom : top;
        rise        = word.pixel_value - state.prev_pixel;
        is_edge     = (word.pixel_value >= state.prev_pixel) && (rise >= cfg.edge_threshold);
        edge_x      = word.column - tct_pkg::COORD_W'(1);
        moved       = 1'b0;

        if (word.column == '0) begin
            st.edge_count = '0;
            st.first_x    = '0;
            st.latest_x   = '0;
            st.before_x   = '0;
        end else if (is_edge) begin
            if (state.edge_count == '0) begin
                st.first_x = edge_x;
            end
            st.before_x = state.latest_x;
            st.latest_x = edge_x;
            if (state.edge_count < tct_pkg::COUNT_MAX) begin
                st.edge_count = state.edge_count + tct_pkg::CNT_W'(1);
            end
            if (!st.found && (32'(st.edge_count) >= 32'(cfg.min_edges))) begin
                st.found     = 1'b1;
                pair.left.x  = edge_x;
                pair.left.y  = word.row_index;
                pair.right.x = st.first_x;
                pair.right.y = word.row_index;
            end
        end
        st.prev_pixel = word.pixel_value;

        meets       = 32'(st.edge_count) >= 32'(cfg.min_edges);
        left_dist   = (word.row_index >= pair.left.y) ? (word.row_index - pair.left.y)
                                                      : (pair.left.y - word.row_index);
        right_dist  = (word.row_index >= pair.right.y) ? (word.row_index - pair.right.y)
                                                       : (pair.right.y - word.row_index);
        left_pitch  = $signed({1'b0, pair.left.x}) - $signed({1'b0, st.first_x});
        right_pitch = $signed({1'b0, st.before_x}) - $signed({1'b0, pair.right.x});
        pitch_limit = $signed({1'b0, cfg.pitch_margin});

        if (word.row_end && meets) begin
            if ((left_dist <= cfg.height_window) && (left_pitch > pitch_limit)) begin
                pair.left.x = st.first_x;
                pair.left.y = word.row_index;
                moved       = 1'b1;
            end
            if ((right_dist <= cfg.height_window) && (right_pitch > pitch_limit)) begin
                pair.right.x = st.before_x;
                pair.right.y = word.row_index;
                moved        = 1'b1;
            end
        end

        state_next  = st;
        top_next    = word.lower_half ? top : pair;
        bottom_next = word.lower_half ? pair : bottom;

        result.half_out      = word.lower_half;
        result.row_out       = word.row_index;
        result.rising_edges  = tct_pkg::COORD_W'(st.edge_count);
        result.left_x        = pair.left.x;
        result.left_y        = pair.left.y;
        result.right_x       = pair.right.x;
        result.right_y       = pair.right.y;
        result.corners_found = st.found;
        result.corners_moved = moved;
    end

endmodule
